// ----- rtl/core/lpht_pkg.sv -----
// Shared types and codes for the linear-probing hash table unit.
// Used by the remainder unit, the slot store, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

  // Fixed field widths of the command and result words.
  localparam int KEY_W      = 31;
  localparam int SIZE_W     = 7;
  localparam int SLOT_OUT_W = 6;
  localparam int FOUND_W    = 32;

  // Remainder unit: dividend bits retired per cycle and the step count.
  localparam int REM_STEP_BITS = 4;
  localparam int REM_STEPS     = (KEY_W + REM_STEP_BITS) / REM_STEP_BITS;
  localparam int REM_CNT_W     = $clog2(REM_STEPS);

  typedef logic [1:0] action_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] slot_state_t;

  // Actions requested by an input word.
  localparam action_t ACT_SEARCH = 2'd0;
  localparam action_t ACT_ADD    = 2'd1;
  localparam action_t ACT_REMOVE = 2'd2;
  localparam action_t ACT_CLEAR  = 2'd3;

  // Result status codes.
  localparam status_t STS_OK      = 2'd0;
  localparam status_t STS_MISS    = 2'd1;
  localparam status_t STS_PRESENT = 2'd2;
  localparam status_t STS_FULL    = 2'd3;

  // Per-slot occupancy codes.
  localparam slot_state_t SLOT_EMPTY    = 2'd0;
  localparam slot_state_t SLOT_OCCUPIED = 2'd1;
  localparam slot_state_t SLOT_DELETED  = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/core/lpht_rem.sv -----
// Iterative remainder unit: key modulo the table size, four dividend bits a cycle.
// Depends on lpht_pkg for widths and step counts.
`timescale 1ns / 1ps
`default_nettype none

module lpht_rem (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [lpht_pkg::KEY_W-1:0]     dividend,
  input  wire logic [lpht_pkg::SIZE_W-1:0]    divisor,
  output logic                                done,
  output logic [lpht_pkg::SIZE_W-1:0]         rem
);

  localparam int DQ_W = lpht_pkg::REM_STEPS * lpht_pkg::REM_STEP_BITS;

  logic                               run;
  logic [lpht_pkg::REM_CNT_W-1:0]     cnt;
  logic [DQ_W-1:0]                    dq;
  logic [lpht_pkg::SIZE_W-1:0]        div_q;
  logic [DQ_W-1:0]                    dq_next;
  logic [lpht_pkg::SIZE_W-1:0]        rem_next;

  // Restoring steps: the partial remainder stays below the divisor, so each
  // step needs one compare and one subtract on eight bits.
  always_comb begin
    logic [lpht_pkg::SIZE_W:0] t;
    rem_next = rem;
    dq_next  = dq;
    for (int k = 0; k < lpht_pkg::REM_STEP_BITS; k++) begin
      t = {rem_next, dq_next[DQ_W-1]};
      dq_next = {dq_next[DQ_W-2:0], 1'b0};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      rem_next = t[lpht_pkg::SIZE_W-1:0];
    end
  end

  // Step sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      run   <= 1'b1;
      cnt   <= '0;
      dq    <= DQ_W'(dividend);
      div_q <= divisor;
      rem   <= '0;
      done  <= 1'b0;
    end else if (run) begin
      dq   <= dq_next;
      rem  <= rem_next;
      cnt  <= cnt + 1'b1;
      run  <= (cnt != lpht_pkg::REM_CNT_W'(lpht_pkg::REM_STEPS - 1));
      done <= (cnt == lpht_pkg::REM_CNT_W'(lpht_pkg::REM_STEPS - 1));
    end else begin
      done <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lpht_store.sv -----
// Slot store: occupancy, key and payload memories with one registered read port
// and one write port. Depends on lpht_pkg for field widths and codes.
`timescale 1ns / 1ps
`default_nettype none

module lpht_store #(
  parameter int SLOTS        = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(SLOTS)-1:0]      rd_addr,
  output lpht_pkg::slot_state_t              rd_state,
  output logic [lpht_pkg::KEY_W-1:0]         rd_key,
  output logic [PAYLOAD_BITS-1:0]            rd_payload,
  input  wire logic                          st_we,
  input  wire logic                          ent_we,
  input  wire logic [$clog2(SLOTS)-1:0]      wr_addr,
  input  wire lpht_pkg::slot_state_t         wr_state,
  input  wire logic [lpht_pkg::KEY_W-1:0]    wr_key,
  input  wire logic [PAYLOAD_BITS-1:0]       wr_payload
);

  lpht_pkg::slot_state_t        st_mem  [SLOTS];
  logic [lpht_pkg::KEY_W-1:0]   key_mem [SLOTS];
  logic [PAYLOAD_BITS-1:0]      pay_mem [SLOTS];

  // Write port. Occupancy is written alone by the clearing sweep and by removes.
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[wr_addr] <= wr_state;
    end
    if (ent_we) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_payload;
    end
  end

  // Registered read port; data appears in the cycle after the read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_state   <= st_mem[rd_addr];
      rd_key     <= key_mem[rd_addr];
      rd_payload <= pay_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/linear_probe_hash_table_unit.sv -----
// Linear-probing hash table with tombstones: sequencer, probe logic and config.
// Depends on lpht_pkg, lpht_rem and lpht_store.
//
//   channel   signals                                  handshake
//   command   action, key, payload                     start & !busy
//   result    status, slot, found_payload              done (one cycle)
//   config    cfg_wdata (table_size)                   cfg_we
//
// A search, add or remove first reduces the key modulo the table size, then
// probes slots from the home slot, one per cycle through the store's read port,
// until a hit, an empty slot or a full pass over the table. A clear sweeps every slot.
// After reset the unit sweeps the occupancy memory with busy high; config
// writes are taken during that time. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table_unit #(
  parameter int SLOTS        = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [lpht_pkg::SIZE_W-1:0]      cfg_wdata,
  input  wire logic                             start,
  input  wire lpht_pkg::action_t                action,
  input  wire logic [lpht_pkg::KEY_W-1:0]       key,
  input  wire logic [PAYLOAD_BITS-1:0]          payload,
  output logic                                  busy,
  output logic                                  done,
  output lpht_pkg::status_t                     status,
  output logic [lpht_pkg::SLOT_OUT_W-1:0]       slot,
  output logic [lpht_pkg::FOUND_W-1:0]          found_payload
);

  localparam int AW        = $clog2(SLOTS);
  localparam int SIZE_MAX  = (SLOTS < 127) ? SLOTS : 127;
  localparam int SIZE_RST  = (SLOTS < 64) ? SLOTS : 64;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_HASH  = 2'd2;
  localparam logic [1:0] S_PROBE = 2'd3;

  logic [1:0]                      fsm, fsm_next;
  logic [lpht_pkg::SIZE_W-1:0]     size_n, size_clamp;
  lpht_pkg::action_t               op_action;
  logic [lpht_pkg::KEY_W-1:0]      op_key;
  logic [PAYLOAD_BITS-1:0]         op_pay;
  logic [AW-1:0]                   sweep_addr;
  logic                            sweep_report;
  logic [AW-1:0]                   iss_addr, iss_addr_next;
  logic [lpht_pkg::SIZE_W-1:0]     iss_cnt;
  logic [AW-1:0]                   rd_addr_q;
  logic [lpht_pkg::SIZE_W-1:0]     rd_idx_q;
  logic                            rd_vld;
  logic                            free_vld;
  logic [AW-1:0]                   free_slot;

  logic                            accept;
  logic                            rem_start, rem_done;
  logic [lpht_pkg::SIZE_W-1:0]     rem;
  logic                            issue;
  lpht_pkg::slot_state_t           rd_state;
  logic [lpht_pkg::KEY_W-1:0]      rd_key;
  logic [PAYLOAD_BITS-1:0]         rd_payload;
  logic                            eval, is_occ, is_empty, hit, last, stop;
  logic [AW-1:0]                   free_pick;
  logic                            free_have;
  logic                            st_we, ent_we;
  logic [AW-1:0]                   wr_addr;
  lpht_pkg::slot_state_t           wr_state;
  logic                            res_valid;
  lpht_pkg::status_t               res_status;
  logic [AW-1:0]                   res_slot;
  logic [PAYLOAD_BITS-1:0]         res_pay;

  assign busy      = (fsm != S_IDLE);
  assign accept    = start && !busy;
  assign rem_start = accept && (action != lpht_pkg::ACT_CLEAR);

  // Table size, clamped into 1..min(SLOTS, 127) when written.
  always_comb begin
    if (cfg_wdata == '0) begin
      size_clamp = lpht_pkg::SIZE_W'(1);
    end else if (32'(cfg_wdata) > SIZE_MAX) begin
      size_clamp = lpht_pkg::SIZE_W'(SIZE_MAX);
    end else begin
      size_clamp = cfg_wdata;
    end
  end

  lpht_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (key),
    .divisor  (size_n),
    .done     (rem_done),
    .rem      (rem)
  );

  // Read issue runs one slot ahead of evaluation; reads have no side effects,
  // so the one read in flight when a probe stops is simply dropped.
  assign issue = (fsm == S_PROBE) && (iss_cnt < size_n);
  assign iss_addr_next = (32'(iss_addr) + 32'd1 == 32'(size_n)) ? '0 : iss_addr + AW'(1);

  lpht_store #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_store (
    .clk        (clk),
    .rd_en      (issue),
    .rd_addr    (iss_addr),
    .rd_state   (rd_state),
    .rd_key     (rd_key),
    .rd_payload (rd_payload),
    .st_we      (st_we),
    .ent_we     (ent_we),
    .wr_addr    (wr_addr),
    .wr_state   (wr_state),
    .wr_key     (op_key),
    .wr_payload (op_pay)
  );

  // Evaluation of the slot word that came back from the store.
  assign eval     = (fsm == S_PROBE) && rd_vld;
  assign is_occ   = (rd_state == lpht_pkg::SLOT_OCCUPIED);
  assign is_empty = (rd_state == lpht_pkg::SLOT_EMPTY);
  assign hit      = is_occ && (rd_key == op_key);
  assign last     = (rd_idx_q == size_n - lpht_pkg::SIZE_W'(1));
  assign stop     = eval && (hit || is_empty || last);

  // First empty or deleted slot on the path is where an add lands.
  assign free_pick = free_vld ? free_slot : rd_addr_q;
  assign free_have = free_vld || !is_occ;

  // Write port control, result formation and next state.
  always_comb begin
    fsm_next   = fsm;
    st_we      = 1'b0;
    ent_we     = 1'b0;
    wr_addr    = sweep_addr;
    wr_state   = lpht_pkg::SLOT_EMPTY;
    res_valid  = 1'b0;
    res_status = lpht_pkg::STS_OK;
    res_slot   = '0;
    res_pay    = '0;
    unique case (fsm)
      S_IDLE: begin
        if (accept) begin
          fsm_next = (action == lpht_pkg::ACT_CLEAR) ? S_SWEEP : S_HASH;
        end
      end
      S_SWEEP: begin
        st_we = 1'b1;
        if (sweep_addr == AW'(SLOTS - 1)) begin
          fsm_next  = S_IDLE;
          res_valid = sweep_report;
        end
      end
      S_HASH: begin
        if (rem_done) begin
          fsm_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stop) begin
          fsm_next  = S_IDLE;
          res_valid = 1'b1;
          unique case (op_action)
            lpht_pkg::ACT_SEARCH: begin
              if (hit) begin
                res_slot = rd_addr_q;
                res_pay  = rd_payload;
              end else begin
                res_status = lpht_pkg::STS_MISS;
              end
            end
            lpht_pkg::ACT_ADD: begin
              if (hit) begin
                res_status = lpht_pkg::STS_PRESENT;
                res_slot   = rd_addr_q;
              end else if (free_have) begin
                st_we    = 1'b1;
                ent_we   = 1'b1;
                wr_addr  = free_pick;
                wr_state = lpht_pkg::SLOT_OCCUPIED;
                res_slot = free_pick;
              end else begin
                res_status = lpht_pkg::STS_FULL;
              end
            end
            lpht_pkg::ACT_REMOVE: begin
              if (hit) begin
                st_we    = 1'b1;
                wr_addr  = rd_addr_q;
                wr_state = lpht_pkg::SLOT_DELETED;
                res_slot = rd_addr_q;
              end else begin
                res_status = lpht_pkg::STS_MISS;
              end
            end
            default: begin
              res_status = lpht_pkg::STS_OK;
            end
          endcase
        end
      end
      default: begin
        fsm_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm          <= S_SWEEP;
      sweep_addr   <= '0;
      sweep_report <= 1'b0;
      size_n       <= lpht_pkg::SIZE_W'(SIZE_RST);
      rd_vld       <= 1'b0;
      free_vld     <= 1'b0;
      done         <= 1'b0;
    end else begin
      fsm    <= fsm_next;
      done   <= res_valid;
      rd_vld <= issue;
      if (cfg_we) begin
        size_n <= size_clamp;
      end
      if (fsm == S_SWEEP) begin
        sweep_addr <= sweep_addr + AW'(1);
      end
      if (accept) begin
        sweep_addr   <= '0;
        sweep_report <= 1'b1;
        free_vld     <= 1'b0;
      end
      if (eval && !is_occ) begin
        free_vld <= 1'b1;
      end
    end
  end

  // Operation word, probe addresses and result word.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_action <= action;
      op_key    <= key;
      op_pay    <= payload;
    end
    if (fsm == S_HASH && rem_done) begin
      iss_addr <= AW'(rem);
      iss_cnt  <= '0;
    end else if (issue) begin
      iss_addr <= iss_addr_next;
      iss_cnt  <= iss_cnt + lpht_pkg::SIZE_W'(1);
    end
    if (issue) begin
      rd_addr_q <= iss_addr;
      rd_idx_q  <= iss_cnt;
    end
    if (eval && !is_occ && !free_vld) begin
      free_slot <= rd_addr_q;
    end
    if (res_valid) begin
      status        <= res_status;
      slot          <= lpht_pkg::SLOT_OUT_W'(res_slot);
      found_payload <= lpht_pkg::FOUND_W'(res_pay);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lpht_check.sv -----
// Port-level checker for the hash table unit, bound to the top level.
// Depends on lpht_pkg for status codes.
`timescale 1ns / 1ps
`default_nettype none

module lpht_check (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              done,
  input wire lpht_pkg::status_t                 status,
  input wire logic [lpht_pkg::SLOT_OUT_W-1:0]   slot,
  input wire logic [lpht_pkg::FOUND_W-1:0]      found_payload
);

  // A result word is shown only once the unit is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word shown while busy");

  // An accepted word makes the unit busy and gives no result in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted word did not start an operation");

  // Only a successful search returns a payload; checked here for any status other than OK.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != lpht_pkg::STS_OK) |-> (found_payload == '0))
    else $error("payload returned on a failed operation");

  // A miss or a full table reports slot zero.
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == lpht_pkg::STS_MISS || status == lpht_pkg::STS_FULL))
      |-> (slot == '0))
    else $error("nonzero slot on a miss or full table");

endmodule

bind linear_probe_hash_table_unit lpht_check u_lpht_check (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .slot          (slot),
  .found_payload (found_payload)
);

`default_nettype wire

// ----- tb/sv/tb_linear_probe_hash_table_unit.sv -----
// Self-checking testbench for linear_probe_hash_table_unit: directed and random
// search, add, remove and clear words over many table sizes, checked by a scoreboard.
// Depends on lpht_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_linear_probe_hash_table_unit;
  import lpht_pkg::*;

  localparam int          TABLE_SLOTS = 64;
  localparam int          IDLE_LIMIT  = 2000;
  localparam int          DRAIN_WAIT  = 100;
  localparam int unsigned PHASE_WORDS = 75;

  typedef struct packed {
    status_t     status;
    logic [5:0]  slot;
    logic [31:0] found;
  } table_reply_t;

  // Scoreboard: holds a shadow copy of the table and the replies still owed.
  class hash_table_scoreboard;
    slot_state_t  occupancy [TABLE_SLOTS];
    logic [30:0]  stored_key [TABLE_SLOTS];
    logic [31:0]  stored_pay [TABLE_SLOTS];
    logic [6:0]   size_reg;
    table_reply_t owed_replies [$];
    int unsigned  errors;

    function new();
      size_reg = 7'd64;
      errors   = 0;
      foreach (occupancy[i]) begin
        occupancy[i]  = SLOT_EMPTY;
        stored_key[i] = '0;
        stored_pay[i] = '0;
      end
    endfunction

    function void set_size(logic [6:0] value);
      size_reg = value;
    endfunction

    // A size of zero acts as one; sizes above the table act as the full table.
    function int unsigned live_slots();
      if (size_reg == 0) return 1;
      if (size_reg > TABLE_SLOTS) return TABLE_SLOTS;
      return size_reg;
    endfunction

    function int unsigned pending();
      return owed_replies.size();
    endfunction

    // Walks the probe path of a key, skipping tombstones, until a match,
    // an empty slot or one full sweep.
    function bit probe_lookup(logic [30:0] k, int unsigned n, output int unsigned where);
      int unsigned s;
      s = k % n;
      where = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (occupancy[s] == SLOT_EMPTY) return 1'b0;
        if (occupancy[s] == SLOT_OCCUPIED && stored_key[s] == k) begin
          where = s;
          return 1'b1;
        end
        s = (s + 1 >= n) ? 0 : s + 1;
      end
      return 1'b0;
    endfunction

    // Applies one accepted word to the shadow table and records its reply.
    function void note_word(action_t act, logic [30:0] k, logic [31:0] pay);
      table_reply_t reply;
      int unsigned  n, where, s;
      reply = '{status: STS_OK, slot: '0, found: '0};
      n = live_slots();
      case (act)
        ACT_SEARCH: begin
          if (probe_lookup(k, n, where)) begin
            reply.slot  = where[5:0];
            reply.found = stored_pay[where];
          end else begin
            reply.status = STS_MISS;
          end
        end
        ACT_ADD: begin
          if (probe_lookup(k, n, where)) begin
            reply.status = STS_PRESENT;
            reply.slot   = where[5:0];
          end else begin
            // Fill the first slot on the path that is empty or a tombstone.
            reply.status = STS_FULL;
            s = k % n;
            for (int unsigned i = 0; i < n; i++) begin
              if (occupancy[s] != SLOT_OCCUPIED) begin
                occupancy[s]  = SLOT_OCCUPIED;
                stored_key[s] = k;
                stored_pay[s] = pay;
                reply.status  = STS_OK;
                reply.slot    = s[5:0];
                break;
              end
              s = (s + 1 >= n) ? 0 : s + 1;
            end
          end
        end
        ACT_REMOVE: begin
          if (probe_lookup(k, n, where)) begin
            occupancy[where] = SLOT_DELETED;
            reply.slot       = where[5:0];
          end else begin
            reply.status = STS_MISS;
          end
        end
        default: begin
          // A clear empties every slot, also those above the current size.
          foreach (occupancy[i]) occupancy[i] = SLOT_EMPTY;
        end
      endcase
      owed_replies.push_back(reply);
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      errors++;
    endtask

    // Compares one result word with the oldest reply owed.
    task check_result(status_t st, logic [5:0] sl, logic [31:0] fp);
      table_reply_t want;
      if (owed_replies.size() == 0) begin
        report($sformatf("result with none expected: status %0d slot %0d payload %h",
                         st, sl, fp));
      end else begin
        want = owed_replies.pop_front();
        if (st !== want.status)
          report($sformatf("status got %0d expected %0d", st, want.status));
        if (sl !== want.slot)
          report($sformatf("slot got %0d expected %0d", sl, want.slot));
        if (fp !== want.found)
          report($sformatf("found_payload got %h expected %h", fp, want.found));
      end
    endtask
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        start     = 1'b0;
  action_t     action    = ACT_SEARCH;
  logic [30:0] key       = '0;
  logic [31:0] payload   = '0;
  logic        busy;
  logic        done;
  status_t     status;
  logic [5:0]  slot;
  logic [31:0] found_payload;

  hash_table_scoreboard sb = new();
  int unsigned          burst_left = 0;
  int unsigned          idle_cycles = 0;
  int unsigned          table_sizes [12] = '{5, 127, 1, 40, 2, 0, 9, 65, 16, 3, 100, 64};

  linear_probe_hash_table_unit #(
    .SLOTS       (TABLE_SLOTS),
    .PAYLOAD_BITS(32)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .start        (start),
    .action       (action),
    .key          (key),
    .payload      (payload),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .slot         (slot),
    .found_payload(found_payload)
  );

  always #5 clk = ~clk;

  // Result checking and the watchdog on cycles with no word moving.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done) sb.check_result(status, slot, found_payload);
      if (done || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Presents one word and holds it until accepted. Called at a rising edge.
  // Words go out in bursts with start held high; a burst ends with a gap.
  task automatic send_word(action_t act, logic [30:0] k, logic [31:0] pay);
    start   <= 1'b1;
    action  <= act;
    key     <= k;
    payload <= pay;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(act, k, pay);
    if (burst_left == 0) begin
      start <= 1'b0;
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(0, 6);
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Drops start after the last word of a phase so it is not taken again.
  task automatic stop_sending();
    if (start) start <= 1'b0;
  endtask

  // Writes table_size once the unit is idle and every reply has come back.
  task automatic write_size(logic [6:0] value);
    while (sb.pending() != 0 || busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    sb.set_size(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random words over a small key pool so that keys collide, are found and
  // are removed often; a few keys come from outside the pool.
  task automatic random_phase(int unsigned count);
    logic [30:0] pool [24];
    int unsigned n, pool_n, pick;
    action_t     act;
    logic [30:0] k;
    logic [31:0] pay;
    n = sb.live_slots();
    pool_n = $urandom_range(4, 24);
    for (int unsigned i = 0; i < pool_n; i++)
      pool[i] = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 4 * n + 3));
    for (int unsigned j = 0; j < count; j++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3)       act = ACT_CLEAR;
      else if (pick < 43) act = ACT_ADD;
      else if (pick < 73) act = ACT_SEARCH;
      else                act = ACT_REMOVE;
      k = ($urandom_range(0, 19) == 0) ? 31'($urandom) : pool[$urandom_range(0, pool_n - 1)];
      case ($urandom_range(0, 9))
        0:       pay = '0;
        1:       pay = '1;
        default: pay = $urandom;
      endcase
      send_word(act, k, pay);
    end
    stop_sending();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_size(7'd64);

    // Full table: collisions, wrap at the top slot, duplicates and tombstones.
    send_word(ACT_SEARCH, 31'd0, 32'h0);
    send_word(ACT_REMOVE, 31'd0, 32'h0);
    send_word(ACT_ADD, 31'd0, 32'hFFFF_FFFF);
    send_word(ACT_ADD, 31'h7FFF_FFFF, 32'h0);
    send_word(ACT_ADD, 31'd64, 32'h1234_5678);
    send_word(ACT_ADD, 31'd127, 32'hA5A5_5A5A);
    send_word(ACT_SEARCH, 31'h7FFF_FFFF, 32'h0);
    send_word(ACT_SEARCH, 31'd127, 32'h0);
    send_word(ACT_ADD, 31'd0, 32'h0BAD_F00D);
    send_word(ACT_REMOVE, 31'd64, 32'h0);
    send_word(ACT_SEARCH, 31'd127, 32'h0);
    send_word(ACT_ADD, 31'd128, 32'h5555_AAAA);
    send_word(ACT_REMOVE, 31'd64, 32'h0);
    send_word(ACT_ADD, 31'd40, 32'hC0DE_0040);
    stop_sending();

    // One slot: full table, a sweep over a tombstone and reuse of it.
    write_size(7'd1);
    send_word(ACT_CLEAR, 31'd0, 32'h0);
    send_word(ACT_ADD, 31'd5, 32'h0000_0005);
    send_word(ACT_ADD, 31'd6, 32'h0000_0006);
    send_word(ACT_SEARCH, 31'd6, 32'h0);
    send_word(ACT_REMOVE, 31'd5, 32'h0);
    send_word(ACT_SEARCH, 31'd5, 32'h0);
    send_word(ACT_ADD, 31'd6, 32'hFEED_0006);
    stop_sending();

    // A size of zero behaves as one slot.
    write_size(7'd0);
    send_word(ACT_SEARCH, 31'd6, 32'h0);
    stop_sending();

    // Back to the full table: the clear reached slot 40, and key 6 now
    // sits off its home slot where no probe finds it.
    write_size(7'd64);
    send_word(ACT_SEARCH, 31'd40, 32'h0);
    send_word(ACT_SEARCH, 31'd6, 32'h0);
    stop_sending();

    // Random phases, one table size each; entries carry over between sizes.
    foreach (table_sizes[i]) begin
      write_size(7'(table_sizes[i]));
      random_phase(PHASE_WORDS);
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lpht_pkg.sv
rtl/core/lpht_rem.sv
rtl/core/lpht_store.sv
rtl/core/linear_probe_hash_table_unit.sv
rtl/core/lpht_check.sv
tb/sv/tb_linear_probe_hash_table_unit.sv
